### sv/assignment_start_time_patcher_macros.svh
// assertion macros for the start time patcher checker
// used by astp_checker.sv, no other dependencies
`ifndef ASSIGNMENT_START_TIME_PATCHER_MACROS_SVH
`define ASSIGNMENT_START_TIME_PATCHER_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen out of reset
`define ASTP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/astp_pkg.sv
// shared types, constants and helpers for the start time patcher
// no dependencies; used by every module of the block
package astp_pkg;

  // frame counter arithmetic
  localparam logic [22:0] Hyperframe = 23'd2715648;
  localparam int unsigned T1Mod      = 1326;
  localparam int unsigned T2Mod      = 26;
  localparam int unsigned T3Mod      = 51;
  localparam int unsigned RecipShift = 22;

  // floor(2^22 / d): estimate is exact or one low for values below 2^22
  localparam logic [17:0] Recip26   = 18'((1 << RecipShift) / T2Mod);
  localparam logic [11:0] Recip1326 = 12'((1 << RecipShift) / T1Mod);
  localparam logic [16:0] Recip51   = 17'((1 << RecipShift) / T3Mod);

  localparam logic [5:0] ExtraDelayReset = 6'd13;

  // base delay by fn mod 26
  localparam logic [3:0] BaseDelay [26] = '{
    4'd8, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd11, 4'd10, 4'd9, 4'd8, 4'd11, 4'd10, 4'd9,
    4'd8, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd11, 4'd10, 4'd9, 4'd8, 4'd11, 4'd10, 4'd9
  };

  typedef enum logic [1:0] {
    ALERT_NONE     = 2'd0,
    ALERT_UPLINK   = 2'd1,
    ALERT_DOWNLINK = 2'd2
  } alert_kind_e;

  // message fields that ride along the pipeline
  typedef struct packed {
    logic        tbf;
    logic [3:0]  rest_hi;
    logic [2:0]  tn;
    logic [9:0]  arfcn;
    logic [7:0]  tag;
    logic [23:0] target;
  } msg_t;

  // starting frame and its T2
  typedef struct packed {
    logic [21:0] start_fn;
    logic [4:0]  t2;
  } frame_t;

  // all timing fields of the starting frame
  typedef struct packed {
    logic [21:0] start_fn;
    logic [4:0]  t1p;
    logic [4:0]  t2;
    logic [5:0]  t3;
  } times_t;

  // mod 26 of a value below 104
  function automatic logic [4:0] mod26_small(logic [6:0] v);
    logic [6:0] r;
    if (v >= 7'(3 * T2Mod)) begin
      r = v - 7'(3 * T2Mod);
    end else if (v >= 7'(2 * T2Mod)) begin
      r = v - 7'(2 * T2Mod);
    end else if (v >= 7'(T2Mod)) begin
      r = v - 7'(T2Mod);
    end else begin
      r = v;
    end
    return r[4:0];
  endfunction

endpackage

### sv/astp_start_calc.sv
// three-stage starting frame calculation: fn mod 26, delay, hyperframe wrap
// depends on astp_pkg
module astp_start_calc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [21:0]         fn_i,
  input  astp_pkg::msg_t      msg_i,
  input  logic [5:0]          extra_delay_i,
  output logic                valid_o,
  output astp_pkg::frame_t    frame_o,
  output astp_pkg::msg_t      msg_o
);

  // stage 1: reciprocal estimate of fn / 26
  logic                 v1_q;
  logic [21:0]          fn1_q;
  logic [17:0]          q26_1_q, q26_1_d;
  astp_pkg::msg_t       msg1_q;
  logic [39:0]          fn_prod;

  assign fn_prod = {18'd0, fn_i} * {22'd0, astp_pkg::Recip26};
  assign q26_1_d = fn_prod[39:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fn1_q   <= fn_i;
    q26_1_q <= q26_1_d;
    msg1_q  <= msg_i;
  end

  // stage 2: remainder with one correction, base delay lookup plus offset
  logic                 v2_q;
  logic [21:0]          fn2_q;
  logic [4:0]           r26_2_q, r26_2_d;
  logic [6:0]           delay2_q, delay2_d;
  astp_pkg::msg_t       msg2_q;
  logic [21:0]          q26_times;
  logic [21:0]          rem_full;
  logic [5:0]           rem6;

  assign q26_times = {4'd0, q26_1_q} * 22'(astp_pkg::T2Mod);
  assign rem_full  = fn1_q - q26_times;
  assign rem6      = rem_full[5:0];
  assign r26_2_d   = (rem6 >= 6'(astp_pkg::T2Mod)) ? 5'(rem6 - 6'(astp_pkg::T2Mod))
                                                   : rem6[4:0];
  assign delay2_d  = 7'(astp_pkg::BaseDelay[r26_2_d]) + 7'(extra_delay_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fn2_q    <= fn1_q;
    r26_2_q  <= r26_2_d;
    delay2_q <= delay2_d;
    msg2_q   <= msg1_q;
  end

  // stage 3: add delay, wrap at hyperframe, T2 from the small remainder
  logic                 v3_q;
  astp_pkg::frame_t     frame3_q, frame3_d;
  astp_pkg::msg_t       msg3_q;
  logic [22:0]          sum;
  logic [22:0]          wrapped;

  assign sum     = {1'b0, fn2_q} + 23'(delay2_q);
  assign wrapped = (sum >= astp_pkg::Hyperframe) ? sum - astp_pkg::Hyperframe : sum;

  always_comb begin
    frame3_d.start_fn = wrapped[21:0];
    frame3_d.t2       = astp_pkg::mod26_small(7'(r26_2_q) + delay2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    frame3_q <= frame3_d;
    msg3_q   <= msg2_q;
  end

  assign valid_o = v3_q;
  assign frame_o = frame3_q;
  assign msg_o   = msg3_q;

endmodule

### sv/astp_time_split.sv
// two-stage split of the starting frame into T1' and T3
// depends on astp_pkg
module astp_time_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  astp_pkg::frame_t    frame_i,
  input  astp_pkg::msg_t      msg_i,
  output logic                valid_o,
  output astp_pkg::times_t    times_o,
  output astp_pkg::msg_t      msg_o
);

  // stage 4: reciprocal estimates of start / 1326 and start / 51
  logic                 v4_q;
  astp_pkg::frame_t     frame4_q;
  astp_pkg::msg_t       msg4_q;
  logic [10:0]          q1_q, q1_d;
  logic [15:0]          q3_q, q3_d;
  logic [33:0]          prod1;
  logic [38:0]          prod3;

  assign prod1 = {12'd0, frame_i.start_fn} * {22'd0, astp_pkg::Recip1326};
  assign prod3 = {17'd0, frame_i.start_fn} * {22'd0, astp_pkg::Recip51};
  assign q1_d  = prod1[32:22];
  assign q3_d  = prod3[37:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    frame4_q <= frame_i;
    msg4_q   <= msg_i;
    q1_q     <= q1_d;
    q3_q     <= q3_d;
  end

  // stage 5: one correction step on each quotient
  logic                 v5_q;
  astp_pkg::times_t     times5_q, times5_d;
  astp_pkg::msg_t       msg5_q;
  logic [21:0]          r1;
  logic [21:0]          r3_full;
  logic [6:0]           r3;

  assign r1      = frame4_q.start_fn - ({11'd0, q1_q} * 22'(astp_pkg::T1Mod));
  assign r3_full = frame4_q.start_fn - ({6'd0, q3_q} * 22'(astp_pkg::T3Mod));
  assign r3      = r3_full[6:0];

  always_comb begin
    times5_d.start_fn = frame4_q.start_fn;
    times5_d.t2       = frame4_q.t2;
    times5_d.t1p      = (r1 >= 22'(astp_pkg::T1Mod)) ? q1_q[4:0] + 5'd1 : q1_q[4:0];
    times5_d.t3       = (r3 >= 7'(astp_pkg::T3Mod)) ? 6'(r3 - 7'(astp_pkg::T3Mod))
                                                    : r3[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    times5_q <= times5_d;
    msg5_q   <= msg4_q;
  end

  assign valid_o = v5_q;
  assign times_o = times5_q;
  assign msg_o   = msg5_q;

endmodule

### sv/assignment_start_time_patcher.sv
// an accepted item passes stages 1 to 5, then the output register, before done_o
// throughput: one item per cycle; busy stays low, six register stages in line
// the two constant-reciprocal multiplier stages set the depth of the pipeline
// reset: asynchronous active low, clears all valid bits, extra delay returns to 13
// results carry a one-cycle done_o strobe; the receiver cannot stall them
// depends on astp_pkg, astp_start_calc, astp_time_split
module assignment_start_time_patcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  input  logic [21:0] fn_i,
  input  logic        tbf_flag_i,
  input  logic [3:0]  rest_octet_hi_i,
  input  logic [2:0]  tn_i,
  input  logic [9:0]  arfcn_i,
  input  logic [7:0]  tag_i,
  input  logic [23:0] target_bytes_i,
  output logic        done_o,
  output logic [23:0] patched_bytes_o,
  output logic [1:0]  alert_kind_o,
  output logic [21:0] start_fn_o,
  output logic [4:0]  start_t1p_o,
  output logic [4:0]  start_t2_o,
  output logic [5:0]  start_t3_o,
  output logic [2:0]  alert_tn_o,
  output logic [9:0]  alert_arfcn_o,
  output logic [7:0]  alert_tag_o
);

  // extra delay register
  logic [5:0] extra_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_delay_q <= astp_pkg::ExtraDelayReset;
    end else if (cfg_we_i) begin
      extra_delay_q <= cfg_data_i;
    end
  end

  // pipeline never holds off an item
  assign busy = 1'b0;

  // pack the message fields
  astp_pkg::msg_t in_msg;

  always_comb begin
    in_msg.tbf     = tbf_flag_i;
    in_msg.rest_hi = rest_octet_hi_i;
    in_msg.tn      = tn_i;
    in_msg.arfcn   = arfcn_i;
    in_msg.tag     = tag_i;
    in_msg.target  = target_bytes_i;
  end

  // starting frame stages
  logic             calc_valid;
  astp_pkg::frame_t calc_frame;
  astp_pkg::msg_t   calc_msg;

  astp_start_calc u_start_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start),
    .fn_i          (fn_i),
    .msg_i         (in_msg),
    .extra_delay_i (extra_delay_q),
    .valid_o       (calc_valid),
    .frame_o       (calc_frame),
    .msg_o         (calc_msg)
  );

  // T1' and T3 stages
  logic             split_valid;
  astp_pkg::times_t split_times;
  astp_pkg::msg_t   split_msg;

  astp_time_split u_time_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (calc_valid),
    .frame_i (calc_frame),
    .msg_i   (calc_msg),
    .valid_o (split_valid),
    .times_o (split_times),
    .msg_o   (split_msg)
  );

  // patch octets and select alert fields
  logic                  rest_present;
  logic                  uplink;
  logic [7:0]            b0, b1, b2;
  logic [23:0]           patched_d;
  astp_pkg::alert_kind_e kind_d;
  astp_pkg::times_t      times_d;
  logic [2:0]            tn_d;
  logic [9:0]            arfcn_d;
  logic [7:0]            tag_d;

  assign rest_present = (split_msg.rest_hi[3:2] == 2'b11);
  assign uplink       = (split_msg.rest_hi[1:0] == 2'b00);

  always_comb begin
    b0        = split_msg.target[23:16];
    b1        = split_msg.target[15:8];
    b2        = split_msg.target[7:0];
    kind_d    = astp_pkg::ALERT_NONE;
    times_d   = '0;
    tn_d      = '0;
    arfcn_d   = '0;
    tag_d     = '0;
    if (split_msg.tbf) begin
      times_d = split_times;
      if (rest_present) begin
        tn_d    = split_msg.tn;
        arfcn_d = split_msg.arfcn;
        if (uplink) begin
          b0     = b0 | {1'b0, split_times.t1p, split_times.t3[5:4]};
          b1     = b1 | {split_times.t3[3:0], split_times.t2[4:1]};
          b2     = b2 | {split_times.t2[0], 7'd0};
          kind_d = astp_pkg::ALERT_UPLINK;
        end else begin
          b0     = b0 | {5'd0, split_times.t1p[4:2]};
          b1     = b1 | {split_times.t1p[1:0], split_times.t3};
          b2     = b2 | {split_times.t2, 3'd0};
          kind_d = astp_pkg::ALERT_DOWNLINK;
          tag_d  = split_msg.tag;
        end
      end
    end
    patched_d = {b0, b1, b2};
  end

  // output register stage
  logic                  done_q;
  logic [23:0]           patched_q;
  astp_pkg::alert_kind_e kind_q;
  astp_pkg::times_t      times_q;
  logic [2:0]            tn_q;
  logic [9:0]            arfcn_q;
  logic [7:0]            tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= split_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    patched_q <= patched_d;
    kind_q    <= kind_d;
    times_q   <= times_d;
    tn_q      <= tn_d;
    arfcn_q   <= arfcn_d;
    tag_q     <= tag_d;
  end

  assign done_o          = done_q;
  assign patched_bytes_o = patched_q;
  assign alert_kind_o    = kind_q;
  assign start_fn_o      = times_q.start_fn;
  assign start_t1p_o     = times_q.t1p;
  assign start_t2_o      = times_q.t2;
  assign start_t3_o      = times_q.t3;
  assign alert_tn_o      = tn_q;
  assign alert_arfcn_o   = arfcn_q;
  assign alert_tag_o     = tag_q;

endmodule

### sv/astp_checker.sv
// port-level checks of the start time patcher, bound to the top level
// depends on astp_pkg and assignment_start_time_patcher_macros.svh
`include "assignment_start_time_patcher_macros.svh"

module astp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  alert_kind_o,
  input logic [21:0] start_fn_o,
  input logic [4:0]  start_t2_o,
  input logic [5:0]  start_t3_o,
  input logic [7:0]  alert_tag_o
);

  // handshake and field conditions seen by the properties
  logic item_taken;
  logic stray_tag;
  logic times_in_range;

  assign item_taken     = start && !busy;
  assign stray_tag      = done_o && (alert_kind_o != astp_pkg::ALERT_DOWNLINK)
                          && (alert_tag_o != 8'd0);
  assign times_in_range = (start_t2_o < 5'd26) && (start_t3_o < 6'd51)
                          && ({1'b0, start_fn_o} < astp_pkg::Hyperframe);

  // every accepted item gives a result on done_o
  `ASTP_ASSERT(a_item_to_result, item_taken |-> ##6 done_o, "item lost in pipeline")

  // no result without an earlier accepted item
  `ASTP_ASSERT(a_result_has_item, done_o |-> $past(item_taken, 6), "invented result")

  // tag only travels with a downlink alert
  `ASTP_NEVER(a_tag_downlink_only, stray_tag, "tag without downlink alert")

  // timing remainders stay in range
  `ASTP_ASSERT(a_time_ranges, done_o |-> times_in_range, "start time field out of range")

  // the pipeline never pushes back
  `ASTP_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind assignment_start_time_patcher astp_checker u_astp_checker (.*);
